@@ src/bru_pkg.sv @@
// Package for the PowerPC branch unit: item and register structs, opcode
// and extended opcode constants and register-write selector codes.
// No dependencies.
`default_nettype none

package bru_pkg;

    localparam logic [1:0] FUNC_WR_COND  = 2'd1;
    localparam logic [1:0] FUNC_WR_LINK  = 2'd2;
    localparam logic [1:0] FUNC_WR_COUNT = 2'd3;

    localparam logic [5:0] OP_BC  = 6'd16;
    localparam logic [5:0] OP_B   = 6'd18;
    localparam logic [5:0] OP_X19 = 6'd19;

    localparam logic [9:0] XO_MCRF   = 10'd0;
    localparam logic [9:0] XO_BCLR   = 10'd16;
    localparam logic [9:0] XO_BCCTR  = 10'd528;
    localparam logic [9:0] XO_ISYNC  = 10'd150;
    localparam logic [9:0] XO_CRAND  = 10'd257;
    localparam logic [9:0] XO_CRANDC = 10'd129;
    localparam logic [9:0] XO_CREQV  = 10'd289;
    localparam logic [9:0] XO_CRNAND = 10'd225;
    localparam logic [9:0] XO_CRNOR  = 10'd33;
    localparam logic [9:0] XO_CROR   = 10'd449;
    localparam logic [9:0] XO_CRORC  = 10'd417;
    localparam logic [9:0] XO_CRXOR  = 10'd193;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] instr;
        logic [31:0] instr_addr;
        logic [31:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_addr;
        logic        taken;
        logic        illegal;
        logic [31:0] cond_value;
        logic [31:0] link_value;
        logic [31:0] count_value;
    } t_out_item;

    typedef struct packed {
        logic [31:0] cond;
        logic [31:0] link;
        logic [31:0] count;
    } t_regs;

endpackage

`default_nettype wire

@@ src/bru_exec.sv @@
// Single-pass execute logic of the branch unit: decodes one item and forms
// the result and the next condition, link and count registers.
// Depends on bru_pkg.
`default_nettype none

module bru_exec (
    input  bru_pkg::t_in_item  i_item,
    input  bru_pkg::t_regs     i_regs,
    output bru_pkg::t_out_item o_result,
    output bru_pkg::t_regs     o_regs
);

    logic [5:0]  op;
    logic [4:0]  f1;
    logic [4:0]  f2;
    logic [4:0]  f3;
    logic [9:0]  xo;
    logic        lk;
    logic        aa;
    logic [31:0] seq;
    logic [31:0] b_disp;
    logic [31:0] bc_disp;
    logic [31:0] b_target;
    logic [31:0] bc_target;
    logic [31:0] ctr_dec;
    logic [4:0]  idx_bi;
    logic [4:0]  idx_bt;
    logic [4:0]  idx_bb;
    logic        ctr_ok;
    logic        cond_ok;
    logic        br_ok;
    logic        bit_a;
    logic        bit_b;
    logic [4:0]  dsh;
    logic [4:0]  ssh;

    assign op  = i_item.instr[31:26];
    assign f1  = i_item.instr[25:21];
    assign f2  = i_item.instr[20:16];
    assign f3  = i_item.instr[15:11];
    assign xo  = i_item.instr[10:1];
    assign aa  = i_item.instr[1];
    assign lk  = i_item.instr[0];
    assign seq = i_item.instr_addr + 32'd4;

    assign b_disp    = {{6{i_item.instr[25]}}, i_item.instr[25:2], 2'b00};
    assign bc_disp   = {{16{i_item.instr[15]}}, i_item.instr[15:2], 2'b00};
    assign b_target  = aa ? b_disp : i_item.instr_addr + b_disp;
    assign bc_target = aa ? bc_disp : i_item.instr_addr + bc_disp;

    // Bit i of the condition register in the architecture's numbering is
    // bit 31 - i of the word.
    assign idx_bi = 5'd31 - f2;
    assign idx_bt = 5'd31 - f1;
    assign idx_bb = 5'd31 - f3;

    assign ctr_dec = i_regs.count - 32'd1;
    assign ctr_ok  = f1[2] || ((ctr_dec != 32'd0) != f1[1]);
    assign cond_ok = f1[4] || (i_regs.cond[idx_bi] == f1[3]);
    assign br_ok   = ctr_ok && cond_ok;

    assign bit_a = i_regs.cond[idx_bi];
    assign bit_b = i_regs.cond[idx_bb];
    assign dsh   = {~f1[4:2], 2'b00};
    assign ssh   = {~f2[4:2], 2'b00};

    always_comb begin
        o_regs   = i_regs;
        o_result = '0;
        case (i_item.func)
            bru_pkg::FUNC_WR_COND: begin
                o_regs.cond = i_item.write_value;
            end
            bru_pkg::FUNC_WR_LINK: begin
                o_regs.link = i_item.write_value;
            end
            bru_pkg::FUNC_WR_COUNT: begin
                o_regs.count = i_item.write_value;
            end
            default: begin
                o_result.next_addr = seq;
                case (op)
                    bru_pkg::OP_B: begin
                        o_result.next_addr = b_target;
                        o_result.taken     = 1'b1;
                        if (lk) begin
                            o_regs.link = seq;
                        end
                    end
                    bru_pkg::OP_BC: begin
                        if (!f1[2]) begin
                            o_regs.count = ctr_dec;
                        end
                        if (br_ok) begin
                            o_result.next_addr = bc_target;
                            o_result.taken     = 1'b1;
                        end
                        if (lk) begin
                            o_regs.link = seq;
                        end
                    end
                    bru_pkg::OP_X19: begin
                        case (xo)
                            bru_pkg::XO_BCLR, bru_pkg::XO_BCCTR: begin
                                if (f3 != 5'd0 ||
                                    (xo == bru_pkg::XO_BCCTR && !f1[2])) begin
                                    o_result.illegal = 1'b1;
                                end else begin
                                    if (!f1[2]) begin
                                        o_regs.count = ctr_dec;
                                    end
                                    if (br_ok) begin
                                        o_result.next_addr = (xo == bru_pkg::XO_BCLR) ?
                                            {i_regs.link[31:2], 2'b00} :
                                            {i_regs.count[31:2], 2'b00};
                                        o_result.taken = 1'b1;
                                    end
                                    if (lk) begin
                                        o_regs.link = seq;
                                    end
                                end
                            end
                            bru_pkg::XO_MCRF: begin
                                if (lk || f1[1:0] != 2'd0 || f2[1:0] != 2'd0 ||
                                    f3 != 5'd0) begin
                                    o_result.illegal = 1'b1;
                                end else begin
                                    o_regs.cond[dsh +: 4] = i_regs.cond[ssh +: 4];
                                end
                            end
                            bru_pkg::XO_ISYNC: begin
                            end
                            bru_pkg::XO_CRAND: begin
                                o_regs.cond[idx_bt] = bit_a & bit_b;
                            end
                            bru_pkg::XO_CRANDC: begin
                                o_regs.cond[idx_bt] = bit_a & ~bit_b;
                            end
                            bru_pkg::XO_CREQV: begin
                                o_regs.cond[idx_bt] = ~(bit_a ^ bit_b);
                            end
                            bru_pkg::XO_CRNAND: begin
                                o_regs.cond[idx_bt] = ~(bit_a & bit_b);
                            end
                            bru_pkg::XO_CRNOR: begin
                                o_regs.cond[idx_bt] = ~(bit_a | bit_b);
                            end
                            bru_pkg::XO_CROR: begin
                                o_regs.cond[idx_bt] = bit_a | bit_b;
                            end
                            bru_pkg::XO_CRORC: begin
                                o_regs.cond[idx_bt] = bit_a | ~bit_b;
                            end
                            bru_pkg::XO_CRXOR: begin
                                o_regs.cond[idx_bt] = bit_a ^ bit_b;
                            end
                            default: begin
                                o_result.illegal = 1'b1;
                            end
                        endcase
                    end
                    default: begin
                        o_result.illegal = 1'b1;
                    end
                endcase
                if (o_result.illegal) begin
                    o_regs             = i_regs;
                    o_result.next_addr = 32'd0;
                    o_result.taken     = 1'b0;
                end
            end
        endcase
        o_result.cond_value  = o_regs.cond;
        o_result.link_value  = o_regs.link;
        o_result.count_value = o_regs.count;
    end

endmodule

`default_nettype wire

@@ src/powerpc_branch_unit.sv @@
// Top level of the PowerPC branch unit: input register, execute logic,
// architectural registers and result register with valid/ready handshakes.
// Depends on bru_pkg and bru_exec.
`default_nettype none

// The unit takes one item per cycle while the output side is not stalled,
// and returns exactly one result item for each, passing through the input
// and result registers. An accepted item waits in the input register; in the
// cycle it moves on, the execute logic reads the condition, link and count
// registers, updates them and loads the result register, so the next item
// already sees the new state. The result register lets a new item enter while
// a finished result waits. After reset all three registers read zero.
// Illegal instructions change no state and report next address zero.
module powerpc_branch_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  bru_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bru_pkg::t_out_item  o_out_item
);

    logic               r_in_valid;
    bru_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    bru_pkg::t_out_item r_out_item;
    bru_pkg::t_regs     r_state;
    bru_pkg::t_regs     n_state;
    bru_pkg::t_out_item n_out_item;
    logic               advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    bru_exec u_exec (
        .i_item   (r_in_item),
        .i_regs   (r_state),
        .o_result (n_out_item),
        .o_regs   (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_illegal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.illegal) |->
            (!r_out_item.taken && r_out_item.next_addr == 32'd0))
        else $error("illegal result carries a branch");

    a_illegal_no_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out_item.illegal) |=> (r_state == $past(r_state)))
        else $error("illegal item changed the registers");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input register lost a waiting item");

    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_item.cond_value == r_state.cond &&
                     r_out_item.link_value == r_state.link &&
                     r_out_item.count_value == r_state.count))
        else $error("result registers disagree with state");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Testbench for powerpc_branch_unit: directed and random instruction items
// are checked against a cycle-independent model of the branch unit registers.
// Depends on bru_pkg and the powerpc_branch_unit RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_EXEC = 2'd0;
    localparam logic [9:0] XO_RFI = 10'd50;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_PHASE_ITEMS = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    bru_pkg::t_in_item  in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    bru_pkg::t_out_item out_item;

    bru_pkg::t_regs     bu_regs = '0;
    bru_pkg::t_out_item expected_results[$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 out_stall_pct = 0;
    int                 quiet_cycles = 0;

    powerpc_branch_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic branch_resolves(input logic [4:0] bo, input logic [4:0] bi);
        logic ctr_ok;
        logic cond_ok;
        ctr_ok = 1'b1;
        cond_ok = 1'b1;
        if (!bo[2]) begin
            bu_regs.count = bu_regs.count - 32'd1;
            ctr_ok = (bu_regs.count != 32'd0) != bo[1];
        end
        if (!bo[4]) begin
            cond_ok = bu_regs.cond[31 - bi] == bo[3];
        end
        return ctr_ok && cond_ok;
    endfunction

    function automatic bru_pkg::t_out_item predict_branch_unit(input bru_pkg::t_in_item it);
        bru_pkg::t_out_item r;
        logic [31:0] ir;
        logic [31:0] pc;
        logic [31:0] seq;
        logic [31:0] target;
        logic [4:0]  f1;
        logic [4:0]  f2;
        logic [4:0]  f3;
        logic [9:0]  xo;
        logic        a;
        logic        b;
        logic        d;
        int          dsh;
        int          ssh;
        r = '0;
        ir = it.instr;
        pc = it.instr_addr;
        f1 = ir[25:21];
        f2 = ir[20:16];
        f3 = ir[15:11];
        xo = ir[10:1];
        seq = pc + 32'd4;
        case (it.func)
            bru_pkg::FUNC_WR_COND: bu_regs.cond = it.write_value;
            bru_pkg::FUNC_WR_LINK: bu_regs.link = it.write_value;
            bru_pkg::FUNC_WR_COUNT: bu_regs.count = it.write_value;
            default: begin
                r.next_addr = seq;
                if (ir[31:26] == bru_pkg::OP_B) begin
                    target = {{6{ir[25]}}, ir[25:2], 2'b00};
                    if (!ir[1]) target = pc + target;
                    r.next_addr = target;
                    r.taken = 1'b1;
                    if (ir[0]) bu_regs.link = seq;
                end else if (ir[31:26] == bru_pkg::OP_BC) begin
                    target = {{16{ir[15]}}, ir[15:2], 2'b00};
                    if (!ir[1]) target = pc + target;
                    if (branch_resolves(f1, f2)) begin
                        r.next_addr = target;
                        r.taken = 1'b1;
                    end
                    if (ir[0]) bu_regs.link = seq;
                end else if (ir[31:26] == bru_pkg::OP_X19) begin
                    case (xo)
                        bru_pkg::XO_BCLR, bru_pkg::XO_BCCTR: begin
                            if (f3 != 5'd0 || (xo == bru_pkg::XO_BCCTR && !f1[2])) begin
                                r.illegal = 1'b1;
                            end else begin
                                target = (xo == bru_pkg::XO_BCLR) ?
                                    bu_regs.link : bu_regs.count;
                                if (branch_resolves(f1, f2)) begin
                                    r.next_addr = {target[31:2], 2'b00};
                                    r.taken = 1'b1;
                                end
                                if (ir[0]) bu_regs.link = seq;
                            end
                        end
                        bru_pkg::XO_MCRF: begin
                            if (ir[0] || f1[1:0] != 2'd0 || f2[1:0] != 2'd0 ||
                                f3 != 5'd0) begin
                                r.illegal = 1'b1;
                            end else begin
                                dsh = (7 - int'(f1[4:2])) * 4;
                                ssh = (7 - int'(f2[4:2])) * 4;
                                bu_regs.cond[dsh +: 4] = bu_regs.cond[ssh +: 4];
                            end
                        end
                        bru_pkg::XO_ISYNC: begin
                        end
                        bru_pkg::XO_CRAND, bru_pkg::XO_CRANDC, bru_pkg::XO_CREQV,
                        bru_pkg::XO_CRNAND, bru_pkg::XO_CRNOR, bru_pkg::XO_CROR,
                        bru_pkg::XO_CRORC, bru_pkg::XO_CRXOR: begin
                            a = bu_regs.cond[31 - f2];
                            b = bu_regs.cond[31 - f3];
                            case (xo)
                                bru_pkg::XO_CRAND: d = a & b;
                                bru_pkg::XO_CRANDC: d = a & ~b;
                                bru_pkg::XO_CREQV: d = ~(a ^ b);
                                bru_pkg::XO_CRNAND: d = ~(a & b);
                                bru_pkg::XO_CRNOR: d = ~(a | b);
                                bru_pkg::XO_CROR: d = a | b;
                                bru_pkg::XO_CRORC: d = a | ~b;
                                default: d = a ^ b;
                            endcase
                            bu_regs.cond[31 - f1] = d;
                        end
                        default: r.illegal = 1'b1;
                    endcase
                end else begin
                    r.illegal = 1'b1;
                end
                if (r.illegal) begin
                    r.next_addr = '0;
                    r.taken = 1'b0;
                end
            end
        endcase
        r.cond_value = bu_regs.cond;
        r.link_value = bu_regs.link;
        r.count_value = bu_regs.count;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    always @(posedge clk) begin : result_check
        bru_pkg::t_out_item want;
        out_ready <= ($urandom_range(99) >= out_stall_pct);
        if (out_valid === 1'b1 && out_ready) begin
            if (expected_results.size() == 0) begin
                flag_error("result item arrived with nothing expected");
            end else begin
                want = expected_results.pop_front();
                check_field("next_addr", out_item.next_addr, want.next_addr);
                check_field("taken", 32'(out_item.taken), 32'(want.taken));
                check_field("illegal", 32'(out_item.illegal), 32'(want.illegal));
                check_field("cond_value", out_item.cond_value, want.cond_value);
                check_field("link_value", out_item.link_value, want.link_value);
                check_field("count_value", out_item.count_value, want.count_value);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input bru_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(predict_branch_unit(it));
    endtask

    function automatic bru_pkg::t_in_item exec_item(input logic [31:0] instr,
                                                    input logic [31:0] pc);
        bru_pkg::t_in_item it;
        it.func = FUNC_EXEC;
        it.instr = instr;
        it.instr_addr = pc;
        it.write_value = $urandom();
        return it;
    endfunction

    function automatic bru_pkg::t_in_item reg_item(input logic [1:0] func,
                                                   input logic [31:0] value);
        bru_pkg::t_in_item it;
        it.func = func;
        it.instr = $urandom();
        it.instr_addr = $urandom();
        it.write_value = value;
        return it;
    endfunction

    function automatic logic [31:0] bc_word(input logic [4:0] bo, input logic [4:0] bi,
                                            input logic [13:0] bd, input logic aa,
                                            input logic lk);
        return {bru_pkg::OP_BC, bo, bi, bd, aa, lk};
    endfunction

    function automatic logic [31:0] xl_word(input logic [4:0] f1, input logic [4:0] f2,
                                            input logic [4:0] f3, input logic [9:0] xo,
                                            input logic lk);
        return {bru_pkg::OP_X19, f1, f2, f3, xo, lk};
    endfunction

    function automatic logic [9:0] random_cr_op();
        case ($urandom_range(7))
            0: return bru_pkg::XO_CRAND;
            1: return bru_pkg::XO_CRANDC;
            2: return bru_pkg::XO_CREQV;
            3: return bru_pkg::XO_CRNAND;
            4: return bru_pkg::XO_CRNOR;
            5: return bru_pkg::XO_CROR;
            6: return bru_pkg::XO_CRORC;
            default: return bru_pkg::XO_CRXOR;
        endcase
    endfunction

    function automatic bru_pkg::t_in_item random_item();
        bru_pkg::t_in_item it;
        int                pick;
        it.func = FUNC_EXEC;
        it.instr = $urandom();
        it.instr_addr = $urandom() & 32'hFFFF_FFFC;
        it.write_value = $urandom();
        if ($urandom_range(15) == 0) it.instr_addr = $urandom();
        pick = $urandom_range(99);
        if (pick < 5) begin
            it.func = bru_pkg::FUNC_WR_COND;
        end else if (pick < 9) begin
            it.func = bru_pkg::FUNC_WR_LINK;
        end else if (pick < 15) begin
            it.func = bru_pkg::FUNC_WR_COUNT;
            if ($urandom_range(1) == 0) it.write_value = $urandom_range(3);
        end else if (pick < 25) begin
            it.instr[31:26] = bru_pkg::OP_B;
        end else if (pick < 40) begin
            it.instr[31:26] = bru_pkg::OP_BC;
        end else if (pick < 62) begin
            it.instr[31:26] = bru_pkg::OP_X19;
            it.instr[10:1] = (pick < 52) ? bru_pkg::XO_BCLR : bru_pkg::XO_BCCTR;
            if ($urandom_range(7) != 0) it.instr[15:11] = 5'd0;
            if (pick >= 52 && $urandom_range(7) != 0) it.instr[23] = 1'b1;
        end else if (pick < 80) begin
            it.instr[31:26] = bru_pkg::OP_X19;
            it.instr[10:1] = random_cr_op();
        end else if (pick < 88) begin
            it.instr[31:26] = bru_pkg::OP_X19;
            it.instr[10:1] = bru_pkg::XO_MCRF;
            if ($urandom_range(3) != 0) begin
                it.instr[22:21] = 2'd0;
                it.instr[17:16] = 2'd0;
                it.instr[15:11] = 5'd0;
                it.instr[0] = 1'b0;
            end
        end else if (pick < 91) begin
            it.instr[31:26] = bru_pkg::OP_X19;
            it.instr[10:1] = bru_pkg::XO_ISYNC;
        end else if (pick < 95) begin
            it.instr[31:26] = bru_pkg::OP_X19;
        end
        return it;
    endfunction

    task automatic test_register_writes();
        send_item(reg_item(bru_pkg::FUNC_WR_COND, 32'hFFFF_FFFF));
        send_item(reg_item(bru_pkg::FUNC_WR_LINK, 32'hFFFF_FFFF));
        send_item(reg_item(bru_pkg::FUNC_WR_COUNT, 32'd1));
    endtask

    task automatic test_branches();
        send_item(exec_item({bru_pkg::OP_B, 24'h7F_FFFF, 1'b0, 1'b1}, 32'hFFFF_FFFC));
        send_item(exec_item({bru_pkg::OP_B, 24'h80_0000, 1'b1, 1'b0}, 32'h0000_1000));
        send_item(exec_item(bc_word(5'b00000, 5'd31, 14'h1FFF, 1'b0, 1'b0), 32'h100));
        send_item(exec_item(bc_word(5'b10010, 5'd0, 14'h2000, 1'b0, 1'b1), 32'h200));
        send_item(exec_item(bc_word(5'b10100, 5'd5, 14'h2000, 1'b1, 1'b0), 32'h300));
        send_item(exec_item(bc_word(5'b01100, 5'd7, 14'h0000, 1'b0, 1'b0), 32'h400));
        send_item(exec_item(xl_word(5'b10100, 5'd0, 5'd0, bru_pkg::XO_BCLR, 1'b1), 32'h500));
        send_item(exec_item(xl_word(5'b10100, 5'd0, 5'd0, bru_pkg::XO_BCCTR, 1'b0), 32'h600));
        // Decrementing form of bcctr is undefined.
        send_item(exec_item(xl_word(5'b10000, 5'd0, 5'd0, bru_pkg::XO_BCCTR, 1'b0), 32'h700));
        send_item(exec_item(xl_word(5'b10100, 5'd0, 5'd1, bru_pkg::XO_BCLR, 1'b0), 32'h800));
    endtask

    task automatic test_condition_ops();
        send_item(reg_item(bru_pkg::FUNC_WR_COND, 32'h5A5A_0F0F));
        send_item(exec_item(xl_word(5'd0, 5'd1, 5'd3, bru_pkg::XO_CRAND, 1'b0), 32'h10));
        send_item(exec_item(xl_word(5'd31, 5'd1, 5'd0, bru_pkg::XO_CRANDC, 1'b1), 32'h14));
        send_item(exec_item(xl_word(5'd2, 5'd20, 5'd28, bru_pkg::XO_CREQV, 1'b0), 32'h18));
        send_item(exec_item(xl_word(5'd3, 5'd31, 5'd30, bru_pkg::XO_CRNAND, 1'b0), 32'h1C));
        send_item(exec_item(xl_word(5'd28, 5'd16, 5'd17, bru_pkg::XO_CRNOR, 1'b0), 32'h20));
        send_item(exec_item(xl_word(5'd17, 5'd0, 5'd16, bru_pkg::XO_CROR, 1'b0), 32'h24));
        send_item(exec_item(xl_word(5'd4, 5'd0, 5'd2, bru_pkg::XO_CRORC, 1'b0), 32'h28));
        send_item(exec_item(xl_word(5'd1, 5'd8, 5'd9, bru_pkg::XO_CRXOR, 1'b0), 32'h2C));
        send_item(exec_item(xl_word(5'd8, 5'd28, 5'd0, bru_pkg::XO_MCRF, 1'b0), 32'h30));
        send_item(exec_item(xl_word(5'd8, 5'd28, 5'd0, bru_pkg::XO_MCRF, 1'b1), 32'h34));
        send_item(exec_item(xl_word(5'd0, 5'd0, 5'd0, bru_pkg::XO_ISYNC, 1'b0), 32'h38));
        send_item(exec_item(32'h0000_0000, 32'h3C));
        send_item(exec_item(xl_word(5'd0, 5'd0, 5'd0, XO_RFI, 1'b0), 32'h40));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        repeat (RANDOM_PHASE_ITEMS) send_item(random_item());
    endtask

    task automatic test_drain_pause();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_writes();
        test_branches();
        test_condition_ops();
        test_random_traffic(0, 0);
        test_drain_pause();
        test_random_traffic(70, 0);
        test_random_traffic(0, 70);
        test_drain_pause();
        test_random_traffic(33, 33);
        test_drain_pause();
        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/bru_pkg.sv
src/bru_exec.sv
src/powerpc_branch_unit.sv
verif/tb.sv
